@@ src/wsfu_pkg.sv @@
// wsfu_pkg: shared types and constants for the WebSocket frame unmasker.
// No dependencies; used by websocket_frame_unmasker_core.
package wsfu_pkg;

  // Header parse phase, one-hot
  typedef enum logic [5:0] {
    PH_FIRST   = 6'b000001,
    PH_SECOND  = 6'b000010,
    PH_EXT     = 6'b000100,
    PH_KEY     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_RAW     = 6'b100000
  } phase_t;

  // Final status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MASKED = 2'd1;
  localparam logic [1:0] ST_SHORT      = 2'd2;
  localparam logic [1:0] ST_MISMATCH   = 2'd3;

  // Extended length size codes
  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_16   = 2'd1;
  localparam logic [1:0] EXT_64   = 2'd2;

  // Header constants
  localparam int unsigned MASK_BIT_POS = 7;
  localparam logic [6:0]  LEN_IS_16    = 7'd126;
  localparam logic [6:0]  LEN_IS_64    = 7'd127;
  localparam logic [3:0]  KEY_BYTES    = 4'd4;
  localparam logic [3:0]  BASE_HDR_LEN = 4'd6;  // two fixed bytes + four key bytes

  localparam int unsigned OUT_TDATA_W = 16;

  // Bytes of extended length for a size code
  function automatic logic [3:0] ext_bytes(input logic [1:0] ext_size);
    logic [3:0] n;
    unique case (ext_size)
      EXT_16:  n = 4'd2;
      EXT_64:  n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

@@ src/websocket_frame_unmasker_core.sv @@
// websocket_frame_unmasker_core: top level of the WebSocket frame unmasker.
// Output: the result of each input transaction is registered in the result register.
// Throughput: 1 byte per cycle unless the consumer stalls; each byte takes one pass through the header parser,
//   whose longest path is the 64-bit payload count increment and length compare.
// Reset: rst_n synchronous, active low; clears parse state and the result valid flag,
//   so the next byte is taken as the first header byte of a new frame.
// Depends on wsfu_pkg.
module websocket_frame_unmasker_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_in
  input  logic        in_tlast,   // last_byte
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [wsfu_pkg::OUT_TDATA_W-1:0] out_tdata,
                                  // [7:0] byte_out, [9:8] status,
                                  // [13:10] payload_offset, [15:14] zero
  output logic        out_tlast   // last_out
);

  // ---------------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------------
  wsfu_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  header_pos_r, header_pos_nxt;   // bytes taken in ext length or key
  logic [63:0] decl_len_r, decl_len_nxt;       // declared payload length
  logic [63:0] pay_cnt_r, pay_cnt_nxt;         // payload bytes seen
  logic [31:0] mask_key_r, mask_key_nxt;       // first key byte ends up in [31:24]
  logic [1:0]  ext_size_r, ext_size_nxt;

  // Result register
  logic        out_valid_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_offset_r, out_offset_nxt;

  logic        in_accept;
  logic [7:0]  b;
  logic [6:0]  len7;
  logic [3:0]  pos_inc;
  logic        end_ok;
  logic [1:0]  status_c;
  logic [7:0]  key_byte;

  // The result register frees up whenever it is empty or being drained, so a
  // new byte enters every cycle unless the consumer stalls.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign b       = in_tdata;
  assign len7    = b[6:0];
  assign pos_inc = header_pos_r + 4'd1;

  // Key byte for this payload byte: index 0 is the first key byte received
  always_comb begin
    unique case (pay_cnt_r[1:0])
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Header parser / unmasker, one byte per pass
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt      = phase_r;
    header_pos_nxt = header_pos_r;
    decl_len_nxt   = decl_len_r;
    pay_cnt_nxt    = pay_cnt_r;
    mask_key_nxt   = mask_key_r;
    ext_size_nxt   = ext_size_r;
    out_byte_nxt   = b;
    status_c       = wsfu_pkg::ST_OK;
    end_ok         = 1'b0;

    unique case (phase_r)
      wsfu_pkg::PH_FIRST: begin
        phase_nxt = wsfu_pkg::PH_SECOND;
        status_c  = wsfu_pkg::ST_SHORT;
      end
      wsfu_pkg::PH_SECOND: begin
        if (len7 == wsfu_pkg::LEN_IS_16) begin
          ext_size_nxt = wsfu_pkg::EXT_16;
          decl_len_nxt = '0;
        end else if (len7 == wsfu_pkg::LEN_IS_64) begin
          ext_size_nxt = wsfu_pkg::EXT_64;
          decl_len_nxt = '0;
        end else begin
          ext_size_nxt = wsfu_pkg::EXT_NONE;
          decl_len_nxt = {57'd0, len7};
        end
        header_pos_nxt = '0;
        if (!b[wsfu_pkg::MASK_BIT_POS]) begin
          phase_nxt = wsfu_pkg::PH_RAW;
          status_c  = wsfu_pkg::ST_NOT_MASKED;
        end else begin
          phase_nxt = (len7 == wsfu_pkg::LEN_IS_16 || len7 == wsfu_pkg::LEN_IS_64)
                      ? wsfu_pkg::PH_EXT : wsfu_pkg::PH_KEY;
          status_c  = wsfu_pkg::ST_SHORT;
        end
      end
      wsfu_pkg::PH_EXT: begin
        // network order: high byte first
        decl_len_nxt   = {decl_len_r[55:0], b};
        header_pos_nxt = pos_inc;
        if (pos_inc >= wsfu_pkg::ext_bytes(ext_size_r)) begin
          header_pos_nxt = '0;
          phase_nxt      = wsfu_pkg::PH_KEY;
        end
        status_c = wsfu_pkg::ST_SHORT;
      end
      wsfu_pkg::PH_KEY: begin
        mask_key_nxt   = {mask_key_r[23:0], b};
        header_pos_nxt = pos_inc;
        if (pos_inc >= wsfu_pkg::KEY_BYTES) begin
          header_pos_nxt = '0;
          phase_nxt      = wsfu_pkg::PH_PAYLOAD;
          end_ok         = 1'b1;  // frame may end here with an empty payload
        end else begin
          status_c = wsfu_pkg::ST_SHORT;
        end
      end
      wsfu_pkg::PH_PAYLOAD: begin
        // bytes past the declared length keep cycling the key
        out_byte_nxt = b ^ key_byte;
        pay_cnt_nxt  = pay_cnt_r + 64'd1;
        end_ok       = 1'b1;
      end
      default: begin  // PH_RAW: unmasked frame passes through
        phase_nxt = wsfu_pkg::PH_RAW;
        status_c  = wsfu_pkg::ST_NOT_MASKED;
      end
    endcase

    out_offset_nxt = '0;
    if (end_ok) begin
      status_c = (pay_cnt_nxt == decl_len_nxt) ? wsfu_pkg::ST_OK : wsfu_pkg::ST_MISMATCH;
    end

    // status and offset are only reported on the final byte
    if (in_tlast) begin
      out_status_nxt = status_c;
      if (end_ok) begin
        out_offset_nxt = wsfu_pkg::BASE_HDR_LEN + wsfu_pkg::ext_bytes(ext_size_r);
      end
    end else begin
      out_status_nxt = wsfu_pkg::ST_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // State and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= wsfu_pkg::PH_FIRST;
      header_pos_r <= '0;
      decl_len_r   <= '0;
      pay_cnt_r    <= '0;
      mask_key_r   <= '0;
      ext_size_r   <= wsfu_pkg::EXT_NONE;
    end else if (in_accept) begin
      if (in_tlast) begin
        // end of frame: back to reset values for the next frame
        phase_r      <= wsfu_pkg::PH_FIRST;
        header_pos_r <= '0;
        decl_len_r   <= '0;
        pay_cnt_r    <= '0;
        mask_key_r   <= '0;
        ext_size_r   <= wsfu_pkg::EXT_NONE;
      end else begin
        phase_r      <= phase_nxt;
        header_pos_r <= header_pos_nxt;
        decl_len_r   <= decl_len_nxt;
        pay_cnt_r    <= pay_cnt_nxt;
        mask_key_r   <= mask_key_nxt;
        ext_size_r   <= ext_size_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload of the result register, loaded on every input transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= in_tlast;
      out_status_r <= out_status_nxt;
      out_offset_r <= out_offset_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_offset_r, out_status_r, out_byte_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a last-byte transaction always returns the parser to the first header byte
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=> (phase_r == wsfu_pkg::PH_FIRST && pay_cnt_r == 64'd0))
    else $error("parser did not restart after last byte");

  // status and offset are zero on every non-final result
  a_status_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_status_r == wsfu_pkg::ST_OK && out_offset_r == 4'd0))
    else $error("status or offset reported on a non-final byte");

  // an offset is only reported with ok or mismatch status
  a_offset_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_offset_r != 4'd0) |->
      (out_status_r == wsfu_pkg::ST_OK || out_status_r == wsfu_pkg::ST_MISMATCH))
    else $error("payload offset with short or unmasked status");

  // header position never runs past the longest extended length
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    header_pos_r < 4'd8)
    else $error("header position out of range");

endmodule
